@@ src/sos_pkg.sv @@
// Shared codes, widths and reset values for the segmented odd-only sieve.
package sos_pkg;

  localparam int VAL_W  = 40;
  localparam int Q_W    = 20;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int WORD_W = 64;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STRIKE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FETCH  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FOUND   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUST = 2'd2;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_LAST = 1'b1;

  localparam logic [VAL_W-1:0] BASE_RST = 40'd3;
  localparam logic [VAL_W-1:0] LAST_RST = 40'd4194306;

endpackage

@@ src/sos_mem.sv @@
// Composite-mark bitmap: one write port, one registered read port.
module sos_mem import sos_pkg::*; #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sos_rem.sv @@
// Iterative restoring remainder unit: 40-bit value modulo 20-bit prime, one bit a cycle.
module sos_rem import sos_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] dividend_i,
  input  logic [Q_W-1:0]   divisor_i,
  output logic             done_o,
  output logic [Q_W-1:0]   rem_o
);

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] dvd_q, dvd_d;
  logic [Q_W-1:0]   dvs_q, dvs_d;
  logic [Q_W-1:0]   r_q, r_d;
  logic [Q_W:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    r_d    = r_q;
    trial  = {r_q, dvd_q[VAL_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VAL_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        r_d = Q_W'(trial - {1'b0, dvs_q});
      end else begin
        r_d = trial[Q_W-1:0];
      end
      dvd_d = {dvd_q[VAL_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

@@ src/segmented_odd_prime_sieve_top.sv @@
// Segmented odd-only sieve: control sequencer around the bitmap memory.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | action_i, sieve_prime_i
//   out     | output    | out_valid_o/out_stall_i| status_o, prime_value_o
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item at a time. Clear: zeroes every bitmap word, one word per cycle. Strike: squares
// q, takes the segment's low odd bound modulo q, then marks each odd multiple, loading and
// writing back each bitmap word it touches. Fetch: scans words for the next unmarked bit.
// After reset the bitmap is swept to zero; no transfer is taken on the input meanwhile.
// The next input is taken while a result waits on out.
module segmented_odd_prime_sieve_top import sos_pkg::*; #(
  parameter int SEGMENT_SPAN = 4194304
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [Q_W-1:0]    sieve_prime_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [VAL_W-1:0]  prime_value_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [VAL_W-1:0]  cfg_data_i
);

  localparam int NBITS   = SEGMENT_SPAN / 2;
  localparam int WORDS   = (NBITS + WORD_W - 1) / WORD_W;
  localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SP_W    = $clog2(NBITS + 1);
  localparam int BIDX_W  = ((SP_W > Q_W) ? SP_W : Q_W) + 1;
  localparam logic [VAL_W-1:0] NBITS_V = VAL_W'(NBITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_SBEG = 4'd4;
  localparam logic [3:0] S_SLD  = 4'd5;
  localparam logic [3:0] S_MARK = 4'd6;
  localparam logic [3:0] S_FST  = 4'd7;
  localparam logic [3:0] S_FCHK = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [VAL_W-1:0]  base_q, last_q;
  logic [SP_W-1:0]   n_q, n_d;
  logic [Q_W-1:0]    q_q, q_d;
  logic [VAL_W-1:0]  qq_q, qq_d;
  logic [BIDX_W-1:0] b_q, b_d;
  logic [WA_W-1:0]   cw_q, cw_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [WA_W-1:0]   fw_q, fw_d;
  logic              first_q, first_d;
  logic [WA_W-1:0]   sweep_q, sweep_d;
  logic              clr_item_q, clr_item_d;
  logic [SP_W-1:0]   scan_q, scan_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [VAL_W-1:0]  res_prime_q, res_prime_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_prime_q, out_prime_d;

  logic              mem_we, mem_re;
  logic [WA_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic              div_start, div_done;
  logic [Q_W-1:0]    div_rem;

  logic [VAL_W-1:0]  lo, diff, nfull;

  sos_mem #(
    .DEPTH (WORDS),
    .AW    (WA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sos_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lo),
    .divisor_i  (q_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign lo    = {base_q[VAL_W-1:1], 1'b1};
  assign diff  = last_q - lo;
  assign nfull = {1'b0, diff[VAL_W-1:1]} + VAL_W'(1);

  always_comb begin
    if (last_q < lo) begin
      n_d = '0;
    end else if (nfull > NBITS_V) begin
      n_d = SP_W'(NBITS);
    end else begin
      n_d = SP_W'(nfull);
    end
  end

  always_comb begin
    logic [Q_W-1:0]     t;
    logic [Q_W:0]       toff;
    logic [VAL_W-1:0]   dqq;
    logic [VAL_W-2:0]   start_w;
    logic               b_in, same;
    logic [WORD_W-1:0]  lowmask, himask, avail;
    logic [SP_W:0]      rem_bits;
    logic [5:0]         ff;
    logic [SP_W-1:0]    idx;

    state_d      = state_q;
    q_d          = q_q;
    qq_d         = qq_q;
    b_d          = b_q;
    cw_d         = cw_q;
    word_d       = word_q;
    fw_d         = fw_q;
    first_d      = first_q;
    sweep_d      = sweep_q;
    clr_item_d   = clr_item_q;
    scan_d       = scan_q;
    res_status_d = res_status_q;
    res_prime_d  = res_prime_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_prime_d  = out_prime_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    div_start    = 1'b0;
    in_stall_o   = 1'b1;

    t        = (div_rem == '0) ? '0 : q_q - div_rem;
    toff     = t[0] ? ({1'b0, t} + {1'b0, q_q}) : {1'b0, t};
    dqq      = qq_q - lo;
    start_w  = (qq_q >= lo) ? dqq[VAL_W-1:1] : (VAL_W-1)'(toff[Q_W:1]);
    b_in     = b_q < BIDX_W'(n_q);
    same     = (b_q >> 6) == BIDX_W'(cw_q);
    rem_bits = {1'b0, n_q} - (SP_W+1)'({fw_q, 6'b0});
    lowmask  = first_q ? ({WORD_W{1'b1}} << scan_q[5:0]) : {WORD_W{1'b1}};
    himask   = (rem_bits >= (SP_W+1)'(WORD_W)) ? {WORD_W{1'b1}}
                                               : ((64'd1 << rem_bits[6:0]) - 64'd1);
    avail    = ~mem_rdata & lowmask & himask;
    if (lo == VAL_W'(1) && fw_q == '0) begin
      avail[0] = 1'b0;
    end
    ff = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (avail[k]) begin
        ff = 6'(k);
      end
    end
    idx = SP_W'({fw_q, ff});

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          q_d = sieve_prime_i;
          res_status_d = STAT_DONE;
          res_prime_d  = '0;
          unique case (action_i)
            ACT_CLEAR: begin
              sweep_d    = '0;
              clr_item_d = 1'b1;
              state_d    = S_CLR;
            end
            ACT_STRIKE: state_d = S_SQ;
            ACT_FETCH:  state_d = S_FST;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        sweep_d   = sweep_q + WA_W'(1);
        if (sweep_q == WA_W'(WORDS - 1)) begin
          scan_d  = '0;
          state_d = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_SQ: begin
        qq_d      = VAL_W'(q_q * q_q);
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_SBEG;
        end
      end
      S_SBEG: begin
        if (n_q == '0 || q_q == '0 || !q_q[0] || start_w >= (VAL_W-1)'(n_q)) begin
          state_d = S_DONE;
        end else begin
          b_d       = BIDX_W'(start_w);
          cw_d      = WA_W'(start_w >> 6);
          mem_re    = 1'b1;
          mem_raddr = WA_W'(start_w >> 6);
          state_d   = S_SLD;
        end
      end
      S_SLD: begin
        word_d  = mem_rdata;
        state_d = S_MARK;
      end
      S_MARK: begin
        if (b_in && same) begin
          word_d = word_q | (64'd1 << b_q[5:0]);
          b_d    = b_q + BIDX_W'(q_q);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cw_q;
          mem_wdata = word_q;
          if (b_in) begin
            mem_re    = 1'b1;
            mem_raddr = WA_W'(b_q >> 6);
            cw_d      = WA_W'(b_q >> 6);
            state_d   = S_SLD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FST: begin
        if (scan_q >= n_q) begin
          res_status_d = STAT_EXHAUST;
          state_d      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = WA_W'(scan_q >> 6);
          fw_d      = WA_W'(scan_q >> 6);
          first_d   = 1'b1;
          state_d   = S_FCHK;
        end
      end
      S_FCHK: begin
        if (|avail) begin
          res_status_d = STAT_FOUND;
          res_prime_d  = lo + VAL_W'({idx, 1'b0});
          scan_d       = idx + SP_W'(1);
          state_d      = S_DONE;
        end else if (rem_bits <= (SP_W+1)'(WORD_W)) begin
          res_status_d = STAT_EXHAUST;
          scan_d       = n_q;
          state_d      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = fw_q + WA_W'(1);
          fw_d      = fw_q + WA_W'(1);
          first_d   = 1'b0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_prime_d  = res_prime_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sweep_q     <= '0;
      clr_item_q  <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      base_q      <= BASE_RST;
      last_q      <= LAST_RST;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_item_q  <= clr_item_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_BASE) begin
        base_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_LAST) begin
        last_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    q_q          <= q_d;
    qq_q         <= qq_d;
    b_q          <= b_d;
    cw_q         <= cw_d;
    word_q       <= word_d;
    fw_q         <= fw_d;
    first_q      <= first_d;
    res_status_q <= res_status_d;
    res_prime_q  <= res_prime_d;
    out_status_q <= out_status_d;
    out_prime_q  <= out_prime_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign prime_value_o = out_prime_q;

endmodule
